>>> hw/rtl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and constants for the decimal radix sort block.
// ----------------------------------------------------------------------------
package lsd_pkg;

	// decimal radix
	localparam int unsigned RADIX = 10;
	localparam int unsigned DIGIT_BITS = 4;

	// external field widths and the stored value width
	localparam int unsigned IN_VALUE_BITS = 16;
	localparam int unsigned OUT_VALUE_BITS = 16;
	localparam int unsigned VALUE_BITS = 16;

	// one queued beat between loader and sorter
	typedef struct packed {
		logic [IN_VALUE_BITS-1:0] value;
		logic                     is_last;
	} lsd_beat_t;

endpackage

>>> hw/rtl/lsd_front.sv
// ----------------------------------------------------------------------------
// lsd_front
// Input stage: takes beats and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
module lsd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                stall,
	input  logic [15:0]         value,
	input  logic                is_last,
	output logic                q_valid,
	input  logic                q_pop,
	output lsd_pkg::lsd_beat_t  q_beat
);

	lsd_pkg::lsd_beat_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign stall   = (cnt_q == 2'd2);
	assign push    = valid && !stall;
	assign q_valid = (cnt_q != 2'd0);
	assign pop     = q_pop && q_valid;
	assign q_beat  = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{value: value, is_last: is_last};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> hw/rtl/lsd_back.sv
// ----------------------------------------------------------------------------
// lsd_back
// Sort engine: stores the set, runs decimal counting-sort passes, emits.
// ----------------------------------------------------------------------------
module lsd_back #(
	parameter int unsigned MAX_ELEMENTS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	output logic                               q_pop,
	input  lsd_pkg::lsd_beat_t                 q_beat,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [lsd_pkg::OUT_VALUE_BITS-1:0] sorted_value,
	output logic                               is_final
);

	localparam int unsigned VB = lsd_pkg::VALUE_BITS;
	localparam int unsigned IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned DW = lsd_pkg::DIGIT_BITS;
	localparam int unsigned PW = VB + 20;

	// reciprocal of ten, exact for values of VB bits after a shift by 19
	localparam logic [16:0] RECIP10 = 17'd52429;

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_MAX   = 4'd1;
	localparam logic [3:0] ST_DIGS  = 4'd2;
	localparam logic [3:0] ST_CLR   = 4'd3;
	localparam logic [3:0] ST_HIST  = 4'd4;
	localparam logic [3:0] ST_PFX   = 4'd5;
	localparam logic [3:0] ST_SCAT  = 4'd6;
	localparam logic [3:0] ST_COPY  = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;

	// per-element steps inside a state
	localparam logic [1:0] SUB_FETCH = 2'd0;
	localparam logic [1:0] SUB_LOAD  = 2'd1;
	localparam logic [1:0] SUB_DIV   = 2'd2;
	localparam logic [1:0] SUB_ACT   = 2'd3;

	logic [3:0]    state_q;
	logic [1:0]    sub_q;
	logic [VB-1:0] elem_q [MAX_ELEMENTS];
	logic [VB-1:0] scr_q  [MAX_ELEMENTS];
	logic [CW-1:0] cnt_q [lsd_pkg::RADIX];
	logic [CW-1:0] n_q;
	logic [CW-1:0] idx_q;
	logic [VB-1:0] max_q;
	logic [VB-1:0] rest_q;
	logic [VB-1:0] quot_q;
	logic [2:0]    digits_q;
	logic [2:0]    pass_q;
	logic [2:0]    divk_q;
	logic [DW-1:0] dig_q;
	logic [DW-1:0] bin_q;
	logic [VB-1:0] elem_rd_s1;
	logic [VB-1:0] scr_rd_s1;
	logic [VB-1:0] obuf_q;
	logic          ofin_q;
	logic          ovalid_q;
	logic [IW-1:0] rd_addr;
	logic [CW-1:0] scat_pos;
	logic [VB-1:0] rest_div10;
	logic          idx_end;
	logic          extract;
	logic          elem_we;
	logic [IW-1:0] elem_wa;
	logic [VB-1:0] elem_wd;
	logic          scr_we;
	logic          out_load;
	logic          out_take;

	// divide by ten by reciprocal multiply
	function automatic logic [VB-1:0] div10(input logic [VB-1:0] x);
		logic [PW-1:0] p;
		p = PW'(x) * PW'(RECIP10);
		return p[VB+18:19];
	endfunction

	// remainder by ten from the exact quotient
	function automatic logic [DW-1:0] mod10(input logic [VB-1:0] x);
		logic [VB-1:0] d;
		logic [VB-1:0] r;
		d = div10(x);
		// d times ten as two shifts
		r = x - ((d << 3) + (d << 1));
		return r[DW-1:0];
	endfunction

	assign q_pop        = (state_q == ST_LOAD);
	assign out_valid    = ovalid_q;
	assign sorted_value = obuf_q;
	assign is_final     = ofin_q;

	assign rd_addr    = idx_q[IW-1:0];
	assign idx_end    = ((idx_q + CW'(1)) == n_q);
	assign scat_pos   = cnt_q[dig_q] - CW'(1);
	assign rest_div10 = div10(rest_q);
	assign extract    = (state_q == ST_HIST || state_q == ST_SCAT) && sub_q != SUB_ACT;

	// store write port: loading or copy back
	assign elem_we = (state_q == ST_LOAD && q_valid && n_q < CW'(MAX_ELEMENTS))
	              || (state_q == ST_COPY && sub_q == SUB_LOAD);
	assign elem_wa = (state_q == ST_LOAD) ? n_q[IW-1:0] : rd_addr;
	assign elem_wd = (state_q == ST_LOAD) ? q_beat.value : scr_rd_s1;
	assign scr_we  = (state_q == ST_SCAT && sub_q == SUB_ACT);

	assign out_take = ovalid_q && !out_stall;
	assign out_load = (state_q == ST_EMIT && sub_q == SUB_LOAD && (!ovalid_q || !out_stall));

	// element store and scratch, registered reads at the walk index
	always_ff @(posedge clk) begin
		if (elem_we) begin
			elem_q[elem_wa] <= elem_wd;
		end
		if (scr_we) begin
			scr_q[scat_pos[IW-1:0]] <= elem_rd_s1;
		end
		elem_rd_s1 <= elem_q[rd_addr];
		scr_rd_s1  <= scr_q[rd_addr];
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			sub_q    <= SUB_FETCH;
			n_q      <= '0;
			idx_q    <= '0;
			max_q    <= '0;
			rest_q   <= '0;
			quot_q   <= '0;
			digits_q <= '0;
			pass_q   <= '0;
			divk_q   <= '0;
			dig_q    <= '0;
			bin_q    <= '0;
			for (int b = 0; b < lsd_pkg::RADIX; b++) cnt_q[b] <= '0;
		end else if (extract) begin
			// digit of the current element: value / 10^pass, then mod 10
			unique case (sub_q)
				SUB_FETCH: sub_q <= SUB_LOAD;
				SUB_LOAD: begin
					quot_q <= elem_rd_s1;
					divk_q <= pass_q;
					sub_q  <= SUB_DIV;
				end
				default: begin
					if (divk_q != '0) begin
						quot_q <= div10(quot_q);
						divk_q <= divk_q - 3'd1;
					end else begin
						dig_q <= mod10(quot_q);
						sub_q <= SUB_ACT;
					end
				end
			endcase
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (q_valid) begin
						if (n_q < CW'(MAX_ELEMENTS)) n_q <= n_q + CW'(1);
						if (q_beat.is_last) begin
							state_q <= ST_MAX;
							sub_q   <= SUB_FETCH;
							idx_q   <= '0;
							max_q   <= '0;
						end
					end
				end
				// find largest over the stored set
				ST_MAX: begin
					if (sub_q == SUB_FETCH) begin
						sub_q <= SUB_LOAD;
					end else begin
						if (elem_rd_s1 > max_q) max_q <= elem_rd_s1;
						sub_q <= SUB_FETCH;
						if (idx_end) begin
							state_q <= ST_DIGS;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				// count decimal digits of the largest value
				ST_DIGS: begin
					if (sub_q == SUB_FETCH) begin
						rest_q   <= max_q;
						digits_q <= 3'd1;
						sub_q    <= SUB_LOAD;
					end else if (rest_div10 != '0) begin
						digits_q <= digits_q + 3'd1;
						rest_q   <= rest_div10;
					end else begin
						pass_q  <= '0;
						state_q <= ST_CLR;
					end
				end
				// clear bins
				ST_CLR: begin
					for (int b = 0; b < lsd_pkg::RADIX; b++) cnt_q[b] <= '0;
					idx_q   <= '0;
					sub_q   <= SUB_FETCH;
					state_q <= ST_HIST;
				end
				// histogram of the digit
				ST_HIST: begin
					cnt_q[dig_q] <= cnt_q[dig_q] + CW'(1);
					sub_q        <= SUB_FETCH;
					if (idx_end) begin
						bin_q   <= DW'(1);
						state_q <= ST_PFX;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				// prefix sum, one bin per cycle
				ST_PFX: begin
					cnt_q[bin_q] <= cnt_q[bin_q] + cnt_q[bin_q - DW'(1)];
					if (bin_q == DW'(lsd_pkg::RADIX - 1)) begin
						idx_q   <= n_q - CW'(1);
						sub_q   <= SUB_FETCH;
						state_q <= ST_SCAT;
					end else begin
						bin_q <= bin_q + DW'(1);
					end
				end
				// backward scatter into scratch
				ST_SCAT: begin
					cnt_q[dig_q] <= scat_pos;
					sub_q        <= SUB_FETCH;
					if (idx_q == '0) begin
						state_q <= ST_COPY;
					end else begin
						idx_q <= idx_q - CW'(1);
					end
				end
				// copy scratch back into the store
				ST_COPY: begin
					if (sub_q == SUB_FETCH) begin
						sub_q <= SUB_LOAD;
					end else begin
						sub_q <= SUB_FETCH;
						if (!idx_end) begin
							idx_q <= idx_q + CW'(1);
						end else if (pass_q + 3'd1 < digits_q) begin
							pass_q  <= pass_q + 3'd1;
							state_q <= ST_CLR;
						end else begin
							idx_q   <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				// emit through the output register
				ST_EMIT: begin
					if (sub_q == SUB_FETCH) begin
						sub_q <= SUB_LOAD;
					end else if (out_load) begin
						sub_q <= SUB_FETCH;
						if (idx_end) begin
							n_q     <= '0;
							idx_q   <= '0;
							max_q   <= '0;
							pass_q  <= '0;
							state_q <= ST_LOAD;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			obuf_q   <= '0;
			ofin_q   <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
			obuf_q   <= elem_rd_s1;
			ofin_q   <= idx_end;
		end else if (out_take) begin
			ovalid_q <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/lsd_decimal_radix_sort.sv
// ----------------------------------------------------------------------------
// lsd_decimal_radix_sort
// LSD base-10 radix sort of a set of up to MAX_ELEMENTS unsigned values.
//
//   channel  dir  beat fields             handshake
//   in       in   value, is_last          in_valid / in_stall
//   out      out  sorted_value, is_final  out_valid / out_stall
//
// loading takes one beat per cycle through a two-entry queue while the sorter
// is loading; in_stall is high while the queue is full, which holds for most of a sort.
// after the last beat of a set: a walk for the max, the digit count, then per
// pass a bin clear, histogram, prefix sum, backward scatter and copy back.
// emission holds each beat in the output register while out_stall is high.
// reset clears all control; stored values need no reset.
// ----------------------------------------------------------------------------
module lsd_decimal_radix_sort #(
	parameter int unsigned MAX_ELEMENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] value,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] sorted_value,
	output logic        is_final
);

	logic               q_valid;
	logic               q_pop;
	lsd_pkg::lsd_beat_t q_beat;

	// front: input queue
	lsd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (in_valid),
		.stall   (in_stall),
		.value   (value),
		.is_last (is_last),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_beat  (q_beat)
	);

	// back: sort engine
	lsd_back #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_beat       (q_beat),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.is_final     (is_final)
	);

endmodule

>>> hw/rtl/lsd_checker.sv
// ----------------------------------------------------------------------------
// lsd_checker
// Port-level checks on the sort block.
// ----------------------------------------------------------------------------
module lsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] sorted_value,
	input logic        is_final
);

	// stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sorted_value) && $stable(is_final))
		else $error("output beat changed under stall");

	// consecutive accepted beats are ascending unless a set ended
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !is_final ##1 out_valid
		|-> sorted_value >= $past(sorted_value))
		else $error("output not ascending");

	// no output valid right after reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("output valid after reset");

	// handshake lines known out of reset
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_stall, out_valid}))
		else $error("handshake line unknown");

endmodule

bind lsd_decimal_radix_sort lsd_checker u_lsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sorted_value (sorted_value),
	.is_final     (is_final)
);

>>> tb/lsd_sort_checker.sv
// ----------------------------------------------------------------------------
// lsd_sort_checker
// Watches both channels of the decimal radix sort block, collects each set
// of input beats, predicts the ascending order of the set and compares every
// output beat, value and final mark, against the oldest prediction.
// ----------------------------------------------------------------------------
module lsd_sort_checker #(
	parameter int unsigned MAX_ELEMENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] value,
	input  logic        is_last,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] sorted_value,
	input  logic        is_final,
	output int          fail_count,
	output int          pending_count
);

	typedef struct {
		logic [15:0] sorted_value;
		logic        is_final;
	} sorted_beat_t;

	logic [15:0]  set_values[$];
	sorted_beat_t sorted_queue[$];

	assign pending_count = sorted_queue.size();

	// stable lsd counting sort, one decimal digit per pass
	task automatic sort_set_and_queue();
		logic [15:0] work[$];
		logic [15:0] scratch[$];
		int          counts[10];
		int          digits;
		int          scale;
		logic [15:0] top;
		int          d;
		sorted_beat_t b;
		work = set_values;
		top = 0;
		foreach (work[i]) if (work[i] > top) top = work[i];
		digits = 1;
		for (int r = top / 10; r != 0; r = r / 10) digits++;
		scale = 1;
		for (int p = 0; p < digits; p++) begin
			for (int k = 0; k < 10; k++) counts[k] = 0;
			foreach (work[i]) counts[(work[i] / scale) % 10]++;
			for (int k = 1; k < 10; k++) counts[k] += counts[k-1];
			scratch = work;
			for (int i = work.size() - 1; i >= 0; i--) begin
				d = (work[i] / scale) % 10;
				counts[d]--;
				scratch[counts[d]] = work[i];
			end
			work = scratch;
			scale = scale * 10;
		end
		foreach (work[i]) begin
			b.sorted_value = work[i];
			b.is_final = (i == work.size() - 1);
			sorted_queue.push_back(b);
		end
		set_values.delete();
	endtask

	// input beats: store until the last mark, extra beats past a full set drop
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_values.delete();
		end else if (in_valid && !in_stall) begin
			if (set_values.size() < MAX_ELEMENTS) set_values.push_back(value);
			if (is_last) sort_set_and_queue();
		end
	end

	// output beats against oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
			sorted_queue.delete();
		end else if (out_valid && !out_stall) begin
			if (sorted_queue.size() == 0) begin
				$display("%0t: expected no beat, got value=%0d final=%0b", $time,
					sorted_value, is_final);
				fail_count <= fail_count + 1;
			end else begin
				if (sorted_value !== sorted_queue[0].sorted_value ||
						is_final !== sorted_queue[0].is_final) begin
					$display("%0t: expected value=%0d final=%0b, got value=%0d final=%0b",
						$time, sorted_queue[0].sorted_value, sorted_queue[0].is_final,
						sorted_value, is_final);
					fail_count <= fail_count + 1;
				end
				void'(sorted_queue.pop_front());
			end
		end
	end

endmodule

>>> tb/lsd_decimal_radix_sort_tb.sv
// ----------------------------------------------------------------------------
// lsd_decimal_radix_sort_tb
// Drives sets of values into the decimal radix sort block under changing
// idle patterns; the checker predicts and compares the sorted output.
// ----------------------------------------------------------------------------
module lsd_decimal_radix_sort_tb;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] value;
	logic        is_last;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] sorted_value;
	logic        is_final;
	int          fail_count;
	int          pending_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          cycle_count = 0;

	lsd_decimal_radix_sort dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .value(value), .is_last(is_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.sorted_value(sorted_value), .is_final(is_final)
	);

	lsd_sort_checker checker_inst (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .value(value), .is_last(is_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.sorted_value(sorted_value), .is_final(is_final),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lsd_decimal_radix_sort: mismatch");
			$finish;
		end
	end

	// one beat, with random idle cycles in front; stall is sampled between edges
	task automatic send_beat(input logic [15:0] v, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		is_last <= last;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic idle_sender();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_value();
		case ($urandom_range(3))
			0: return 16'($urandom_range(9));
			1: return 16'($urandom_range(999));
			2: return 16'($urandom_range(65535));
			default: return ($urandom_range(1) ? 16'hffff : 16'h0000);
		endcase
	endfunction

	task automatic send_set(input int n);
		for (int i = 0; i < n; i++) send_beat(rand_value(), i == n - 1);
	endtask

	initial begin
		int sent;
		int n;
		arst_n = 0;
		in_valid = 0;
		value = 0;
		is_last = 0;
		send_idle_pct = 13;
		recv_idle_pct = 53;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: single element, extremes, ties
		send_beat(16'd0, 1'b1);
		send_beat(16'hffff, 1'b1);
		send_beat(16'd65535, 1'b0);
		send_beat(16'd0, 1'b0);
		send_beat(16'd10, 1'b0);
		send_beat(16'd9, 1'b0);
		send_beat(16'd100, 1'b0);
		send_beat(16'd10, 1'b0);
		send_beat(16'haaaa, 1'b0);
		send_beat(16'h5555, 1'b1);
		send_beat(16'd7, 1'b0);
		send_beat(16'd7, 1'b1);
		// pause until every sorted beat has come
		idle_sender();
		while (pending_count != 0) @(posedge clk);
		// full set plus dropped overflow beats, last mark on a dropped beat
		for (int i = 0; i < 66; i++) send_beat(rand_value(), i == 65);

		// random sets through three idle patterns
		sent = 0;
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 53;
				recv_idle_pct = 13;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			while (sent < 27 * (phase + 1)) begin
				n = ($urandom_range(7) == 0) ? $urandom_range(64, 20) : $urandom_range(12, 1);
				if (n > 27 * (phase + 1) - sent) n = 27 * (phase + 1) - sent;
				send_set(n);
				sent += n;
			end
		end
		idle_sender();

		while (pending_count != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("lsd_decimal_radix_sort: match");
		end else begin
			$display("lsd_decimal_radix_sort: mismatch");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/lsd_pkg.sv
hw/rtl/lsd_front.sv
hw/rtl/lsd_back.sv
hw/rtl/lsd_decimal_radix_sort.sv
hw/rtl/lsd_checker.sv
tb/lsd_sort_checker.sv
tb/lsd_decimal_radix_sort_tb.sv
